[hdl/psched_pkg.sv]
// Shared constants, codes and types of the process scheduler.
package psched_pkg;

    localparam int P_MAX_PROCS = 64;

    localparam int CMD_W   = 2;
    localparam int ALGO_W  = 2;
    localparam int STAT_W  = 2;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int MS_W    = 16;
    localparam int WAIT_W  = 32;
    localparam int CNT_W   = 32;
    localparam int UTIL_W  = 15;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_SPAWN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [ALGO_W-1:0] ALG_RR   = 2'd0;
    localparam logic [ALGO_W-1:0] ALG_PRIO = 2'd1;
    localparam logic [ALGO_W-1:0] ALG_SJF  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_PID   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALGO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK    = 2'd2;

    localparam logic [MS_W-1:0]   QUANTUM_RST = 16'd100;
    localparam logic [MS_W-1:0]   TICK_RST    = 16'd10;
    localparam logic [UTIL_W-1:0] UTIL_BUSY   = 15'd2560;
    localparam logic [UTIL_W-1:0] UTIL_MAX    = 15'd25600;
    // floor(u/10) == (u * 52429) >> 19 for every u below 43699
    localparam logic [15:0]       DIV10_MUL   = 16'd52429;
    localparam int                DIV10_SH    = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } sched_state_t;

    typedef struct packed {
        logic take_next;
        logic load_new;
        logic accrue;
    } cell_ctrl_t;

endpackage

[hdl/psched_cell.sv]
// One queue cell: holds one ready entry and one stage of the selection wave.
module psched_cell #(
    parameter int SLOT_W = 6,
    parameter int POS    = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psched_pkg::cell_ctrl_t        ctrl,
    input  logic                          key_sel,
    input  logic [SLOT_W-1:0]             tslot,
    input  logic [psched_pkg::MS_W-1:0]   tick_ms,
    input  logic [SLOT_W-1:0]             new_slot,
    input  logic [psched_pkg::PRIO_W-1:0] new_prio,
    input  logic [psched_pkg::BURST_W-1:0] new_rem,
    input  logic [psched_pkg::WAIT_W-1:0] new_wait,
    input  logic                          nxt_valid,
    input  logic [SLOT_W-1:0]             nxt_slot,
    input  logic [psched_pkg::PRIO_W-1:0] nxt_prio,
    input  logic [psched_pkg::BURST_W-1:0] nxt_rem,
    input  logic [psched_pkg::WAIT_W-1:0] nxt_wait,
    output logic                          valid,
    output logic [SLOT_W-1:0]             slot,
    output logic [psched_pkg::PRIO_W-1:0] prio,
    output logic [psched_pkg::BURST_W-1:0] rem,
    output logic [psched_pkg::WAIT_W-1:0] waitv,
    input  logic                          si_bvalid,
    input  logic [SLOT_W-1:0]             si_bpos,
    input  logic [SLOT_W-1:0]             si_bslot,
    input  logic [psched_pkg::PRIO_W-1:0] si_bprio,
    input  logic [psched_pkg::BURST_W-1:0] si_brem,
    input  logic [psched_pkg::WAIT_W-1:0] si_bwait,
    input  logic                          si_hit,
    input  logic [SLOT_W-1:0]             si_hpos,
    output logic                          so_bvalid,
    output logic [SLOT_W-1:0]             so_bpos,
    output logic [SLOT_W-1:0]             so_bslot,
    output logic [psched_pkg::PRIO_W-1:0] so_bprio,
    output logic [psched_pkg::BURST_W-1:0] so_brem,
    output logic [psched_pkg::WAIT_W-1:0] so_bwait,
    output logic                          so_hit,
    output logic [SLOT_W-1:0]             so_hpos
);
    import psched_pkg::*;

    logic                 valid_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [BURST_W-1:0]   rem_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic [WAIT_W:0]      wait_sum;
    logic [WAIT_W-1:0]    wait_acc;
    logic [BURST_W-1:0]   my_key;
    logic [BURST_W-1:0]   in_key;
    logic                 take_best;
    logic                 take_hit;

    logic                 bvalid_reg;
    logic [SLOT_W-1:0]    bpos_reg;
    logic [SLOT_W-1:0]    bslot_reg;
    logic [PRIO_W-1:0]    bprio_reg;
    logic [BURST_W-1:0]   brem_reg;
    logic [WAIT_W-1:0]    bwait_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    hpos_reg;

    // saturating wait accrual
    always_comb
    begin
        wait_sum = {1'b0, wait_reg} + {{(WAIT_W+1-MS_W){1'b0}}, tick_ms};
        wait_acc = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load_new)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctrl.take_next)
        begin
            valid_reg <= nxt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            slot_reg <= new_slot;
            prio_reg <= new_prio;
            rem_reg  <= new_rem;
            wait_reg <= new_wait;
        end
        else if (ctrl.take_next)
        begin
            slot_reg <= nxt_slot;
            prio_reg <= nxt_prio;
            rem_reg  <= nxt_rem;
            wait_reg <= nxt_wait;
        end
        else if (ctrl.accrue && valid_reg)
        begin
            wait_reg <= wait_acc;
        end
    end

    // selection wave: an earlier entry keeps the lead unless strictly beaten
    always_comb
    begin
        my_key    = key_sel ? {{(BURST_W-PRIO_W){1'b0}}, prio_reg} : rem_reg;
        in_key    = key_sel ? {{(BURST_W-PRIO_W){1'b0}}, si_bprio} : si_brem;
        take_best = valid_reg && (!si_bvalid || (my_key < in_key));
        take_hit  = valid_reg && !si_hit && (slot_reg == tslot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            bvalid_reg <= si_bvalid || valid_reg;
            hit_reg    <= si_hit || take_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            bpos_reg  <= SLOT_W'(POS);
            bslot_reg <= slot_reg;
            bprio_reg <= prio_reg;
            brem_reg  <= rem_reg;
            bwait_reg <= wait_reg;
        end
        else
        begin
            bpos_reg  <= si_bpos;
            bslot_reg <= si_bslot;
            bprio_reg <= si_bprio;
            brem_reg  <= si_brem;
            bwait_reg <= si_bwait;
        end
        hpos_reg <= take_hit ? SLOT_W'(POS) : si_hpos;
    end

    assign valid     = valid_reg;
    assign slot      = slot_reg;
    assign prio      = prio_reg;
    assign rem       = rem_reg;
    assign waitv     = wait_reg;
    assign so_bvalid = bvalid_reg;
    assign so_bpos   = bpos_reg;
    assign so_bslot  = bslot_reg;
    assign so_bprio  = bprio_reg;
    assign so_brem   = brem_reg;
    assign so_bwait  = bwait_reg;
    assign so_hit    = hit_reg;
    assign so_hpos   = hpos_reg;

endmodule

[hdl/process_scheduler_rr_priority_sjf_top.sv]
// Process scheduler top: command sequencer, runner state and the queue cell chain.
//
//  channel | signals                         | beat moves
//  --------+---------------------------------+------------------------------
//  in      | in_valid / in_stall             | cmd, target_pid, priority_req, burst_len
//  out     | out_valid / out_stall           | status .. utilization, one per input
//  cfg     | cfg_we, cfg_index, cfg_data     | algorithm, quantum_ms, tick_ms
//
//  Spawn passes through APPLY to DONE, unknown commands go straight to DONE; kill
//  scans the chain before APPLY; a tick runs APPLY, RUN and FIN, with a scan first
//  when priority or SJF must select a new runner. The scan crosses all MAX_PROCS cells.
//  Reset clears the queue, table count, runner and counters and sets config defaults.
//  in_stall is high while an item is in work; a stalled result holds in the
//  output register while the next item is taken.
module process_scheduler_rr_priority_sjf_top #(
    parameter int MAX_PROCS = psched_pkg::P_MAX_PROCS,
    parameter int PID_W     = $clog2(MAX_PROCS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psched_pkg::CFG_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [psched_pkg::CMD_W-1:0]      cmd,
    input  logic [PID_W-1:0]                  target_pid,
    input  logic [psched_pkg::PRIO_W-1:0]     priority_req,
    input  logic [psched_pkg::BURST_W-1:0]    burst_len,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [psched_pkg::STAT_W-1:0]     status,
    output logic [PID_W-1:0]                  new_pid,
    output logic [PID_W-1:0]                  run_pid,
    output logic [PID_W-1:0]                  finished_pid,
    output logic [psched_pkg::WAIT_W-1:0]     finished_wait_ms,
    output logic                              preempted,
    output logic [psched_pkg::CNT_W-1:0]      tick_count,
    output logic [psched_pkg::CNT_W-1:0]      switch_count,
    output logic [psched_pkg::UTIL_W-1:0]     utilization
);
    import psched_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCS);

    sched_state_t state_reg, state_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;

    logic [ALGO_W-1:0]  algo_reg;
    logic [MS_W-1:0]    quantum_reg;
    logic [MS_W-1:0]    tick_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [PID_W-1:0]   tpid_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [BURST_W-1:0] burst_reg;

    logic [PID_W-1:0]   size_reg;
    logic [PID_W-1:0]   used_reg;
    logic [PID_W-1:0]   runner_reg;
    logic [BURST_W-1:0] run_rem_reg;
    logic [WAIT_W-1:0]  run_wait_reg;
    logic [PRIO_W-1:0]  run_prio_reg;
    logic [CNT_W-1:0]   ticks_reg;
    logic [CNT_W-1:0]   sw_reg;
    logic [UTIL_W-1:0]  util_reg;

    logic [STAT_W-1:0]  st_reg;
    logic [PID_W-1:0]   npid_reg;
    logic [PID_W-1:0]   fpid_reg;
    logic [WAIT_W-1:0]  fwait_reg;
    logic               pre_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  o_status_reg;
    logic [PID_W-1:0]   o_npid_reg;
    logic [PID_W-1:0]   o_run_reg;
    logic [PID_W-1:0]   o_fpid_reg;
    logic [WAIT_W-1:0]  o_fwait_reg;
    logic               o_pre_reg;
    logic [CNT_W-1:0]   o_ticks_reg;
    logic [CNT_W-1:0]   o_sw_reg;
    logic [UTIL_W-1:0]  o_util_reg;

    // chain wiring: entry arrays carry cell i at index i, a tied-off tail at MAX_PROCS
    logic               e_valid [MAX_PROCS+1];
    logic [SLOT_W-1:0]  e_slot  [MAX_PROCS+1];
    logic [PRIO_W-1:0]  e_prio  [MAX_PROCS+1];
    logic [BURST_W-1:0] e_rem   [MAX_PROCS+1];
    logic [WAIT_W-1:0]  e_wait  [MAX_PROCS+1];
    // wave arrays: index 0 is the empty seed, cell i drives index i+1
    logic               s_bvalid [MAX_PROCS+1];
    logic [SLOT_W-1:0]  s_bpos   [MAX_PROCS+1];
    logic [SLOT_W-1:0]  s_bslot  [MAX_PROCS+1];
    logic [PRIO_W-1:0]  s_bprio  [MAX_PROCS+1];
    logic [BURST_W-1:0] s_brem   [MAX_PROCS+1];
    logic [WAIT_W-1:0]  s_bwait  [MAX_PROCS+1];
    logic               s_hit    [MAX_PROCS+1];
    logic [SLOT_W-1:0]  s_hpos   [MAX_PROCS+1];

    logic               in_accept;
    logic               out_load;
    logic               key_sel;
    logic [SLOT_W-1:0]  tslot;
    logic               sel_scan;
    logic               need_pick;
    logic               spawn_full;
    logic               kill_ok;
    logic               rm_en;
    logic [SLOT_W-1:0]  rm_pos;
    logic               ap_en;
    logic [SLOT_W-1:0]  ap_pos;
    logic               accrue;
    logic [SLOT_W-1:0]  new_slot;
    logic [PRIO_W-1:0]  new_prio;
    logic [BURST_W-1:0] new_rem;
    logic [WAIT_W-1:0]  new_wait;
    logic [MS_W-1:0]    slice;
    logic [BURST_W-1:0] rem_after;
    logic               run_finish;
    logic               run_push;
    logic [SLOT_W-1:0]  pick_slot;
    logic [PRIO_W-1:0]  pick_prio;
    logic [BURST_W-1:0] pick_rem;
    logic [WAIT_W-1:0]  pick_wait;
    logic [UTIL_W+15:0] util_prod;
    logic [UTIL_W-1:0]  util_tenth;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign key_sel   = (algo_reg == ALG_PRIO);
    assign tslot     = SLOT_W'(tpid_reg - PID_W'(1));
    assign sel_scan  = (algo_reg == ALG_PRIO) || (algo_reg == ALG_SJF);
    assign need_pick = (runner_reg == '0) && (size_reg != '0);

    assign e_valid[MAX_PROCS] = 1'b0;
    assign e_slot[MAX_PROCS]  = '0;
    assign e_prio[MAX_PROCS]  = '0;
    assign e_rem[MAX_PROCS]   = '0;
    assign e_wait[MAX_PROCS]  = '0;
    assign s_bvalid[0] = 1'b0;
    assign s_bpos[0]   = '0;
    assign s_bslot[0]  = '0;
    assign s_bprio[0]  = '0;
    assign s_brem[0]   = '0;
    assign s_bwait[0]  = '0;
    assign s_hit[0]    = 1'b0;
    assign s_hpos[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PROCS; gi++)
        begin : g_cell
            cell_ctrl_t cctl;

            always_comb
            begin
                cctl.take_next = rm_en && (SLOT_W'(gi) >= rm_pos);
                cctl.load_new  = ap_en && (SLOT_W'(gi) == ap_pos);
                cctl.accrue    = accrue;
            end

            psched_cell #(
                .SLOT_W (SLOT_W),
                .POS    (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cctl),
                .key_sel   (key_sel),
                .tslot     (tslot),
                .tick_ms   (tick_reg),
                .new_slot  (new_slot),
                .new_prio  (new_prio),
                .new_rem   (new_rem),
                .new_wait  (new_wait),
                .nxt_valid (e_valid[gi+1]),
                .nxt_slot  (e_slot[gi+1]),
                .nxt_prio  (e_prio[gi+1]),
                .nxt_rem   (e_rem[gi+1]),
                .nxt_wait  (e_wait[gi+1]),
                .valid     (e_valid[gi]),
                .slot      (e_slot[gi]),
                .prio      (e_prio[gi]),
                .rem       (e_rem[gi]),
                .waitv     (e_wait[gi]),
                .si_bvalid (s_bvalid[gi]),
                .si_bpos   (s_bpos[gi]),
                .si_bslot  (s_bslot[gi]),
                .si_bprio  (s_bprio[gi]),
                .si_brem   (s_brem[gi]),
                .si_bwait  (s_bwait[gi]),
                .si_hit    (s_hit[gi]),
                .si_hpos   (s_hpos[gi]),
                .so_bvalid (s_bvalid[gi+1]),
                .so_bpos   (s_bpos[gi+1]),
                .so_bslot  (s_bslot[gi+1]),
                .so_bprio  (s_bprio[gi+1]),
                .so_brem   (s_brem[gi+1]),
                .so_bwait  (s_bwait[gi+1]),
                .so_hit    (s_hit[gi+1]),
                .so_hpos   (s_hpos[gi+1])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_SPAWN: state_next = ST_APPLY;
                        CMD_KILL:  state_next = ST_SCAN;
                        CMD_TICK:  state_next = (need_pick && sel_scan) ? ST_SCAN : ST_APPLY;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == SLOT_W'(MAX_PROCS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = (cmd_reg == CMD_TICK) ? ST_RUN : ST_DONE;
            ST_RUN:   state_next = ST_FIN;
            ST_FIN:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control decode
    always_comb
    begin
        cnt_next   = (state_reg == ST_SCAN) ? cnt_reg + SLOT_W'(1) : '0;
        spawn_full = (used_reg == PID_W'(MAX_PROCS));
        kill_ok    = (tpid_reg != '0) && (tpid_reg <= used_reg)
                     && (s_hit[MAX_PROCS] || (runner_reg == tpid_reg));
        slice      = (algo_reg == ALG_RR) ? quantum_reg : tick_reg;
        rem_after  = (slice < run_rem_reg) ? run_rem_reg - slice : '0;
        run_finish = (runner_reg != '0) && (rem_after == '0);
        run_push   = (runner_reg != '0) && !run_finish && (algo_reg == ALG_RR);
        pick_slot  = sel_scan ? s_bslot[MAX_PROCS] : e_slot[0];
        pick_prio  = sel_scan ? s_bprio[MAX_PROCS] : e_prio[0];
        pick_rem   = sel_scan ? s_brem[MAX_PROCS]  : e_rem[0];
        pick_wait  = sel_scan ? s_bwait[MAX_PROCS] : e_wait[0];
        rm_en      = 1'b0;
        rm_pos     = '0;
        ap_en      = 1'b0;
        ap_pos     = SLOT_W'(size_reg);
        accrue     = 1'b0;
        new_slot   = SLOT_W'(runner_reg - PID_W'(1));
        new_prio   = run_prio_reg;
        new_rem    = rem_after;
        new_wait   = run_wait_reg;
        case (state_reg)
            ST_APPLY:
            begin
                case (cmd_reg)
                    CMD_SPAWN:
                    begin
                        ap_en    = !spawn_full;
                        new_slot = SLOT_W'(used_reg);
                        new_prio = prio_reg;
                        new_rem  = burst_reg;
                        new_wait = '0;
                    end
                    CMD_KILL:
                    begin
                        rm_en  = kill_ok && s_hit[MAX_PROCS];
                        rm_pos = s_hpos[MAX_PROCS];
                    end
                    CMD_TICK:
                    begin
                        rm_en  = need_pick;
                        rm_pos = sel_scan ? s_bpos[MAX_PROCS] : '0;
                    end
                    default:
                    begin
                        rm_en = 1'b0;
                    end
                endcase
            end
            ST_RUN:
            begin
                accrue = (runner_reg != '0);
                ap_en  = run_push;
            end
            default:
            begin
                rm_en = 1'b0;
            end
        endcase
    end

    // u/10 by reciprocal
    assign util_prod  = util_reg * DIV10_MUL;
    assign util_tenth = UTIL_W'(util_prod >> DIV10_SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            algo_reg      <= ALG_RR;
            quantum_reg   <= QUANTUM_RST;
            tick_reg      <= TICK_RST;
            size_reg      <= '0;
            used_reg      <= '0;
            runner_reg    <= '0;
            ticks_reg     <= '0;
            sw_reg        <= '0;
            util_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALGO:    algo_reg    <= cfg_data[ALGO_W-1:0];
                    REG_QUANTUM: quantum_reg <= cfg_data[MS_W-1:0];
                    REG_TICK:    tick_reg    <= cfg_data[MS_W-1:0];
                    default:     algo_reg    <= algo_reg;
                endcase
            end
            if (state_reg == ST_APPLY)
            begin
                case (cmd_reg)
                    CMD_SPAWN:
                    begin
                        if (!spawn_full)
                        begin
                            used_reg <= used_reg + PID_W'(1);
                            size_reg <= size_reg + PID_W'(1);
                        end
                    end
                    CMD_KILL:
                    begin
                        if (rm_en)
                        begin
                            size_reg <= size_reg - PID_W'(1);
                        end
                        if (kill_ok && (runner_reg == tpid_reg))
                        begin
                            runner_reg <= '0;
                        end
                    end
                    CMD_TICK:
                    begin
                        ticks_reg <= ticks_reg + CNT_W'(1);
                        if (need_pick)
                        begin
                            size_reg   <= size_reg - PID_W'(1);
                            runner_reg <= PID_W'(pick_slot) + PID_W'(1);
                        end
                    end
                    default:
                    begin
                        size_reg <= size_reg;
                    end
                endcase
            end
            if (state_reg == ST_RUN)
            begin
                if (run_finish || run_push)
                begin
                    runner_reg <= '0;
                    sw_reg     <= sw_reg + CNT_W'(1);
                end
                if (run_push)
                begin
                    size_reg <= size_reg + PID_W'(1);
                end
            end
            if (state_reg == ST_FIN)
            begin
                util_reg <= util_reg - util_tenth + ((runner_reg != '0) ? UTIL_BUSY : '0);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= cmd;
            tpid_reg  <= target_pid;
            prio_reg  <= priority_req;
            burst_reg <= burst_len;
            st_reg    <= STAT_OK;
            npid_reg  <= '0;
            fpid_reg  <= '0;
            fwait_reg <= '0;
            pre_reg   <= 1'b0;
        end
        if (state_reg == ST_APPLY)
        begin
            case (cmd_reg)
                CMD_SPAWN:
                begin
                    if (spawn_full)
                    begin
                        st_reg <= STAT_FULL;
                    end
                    else
                    begin
                        npid_reg <= used_reg + PID_W'(1);
                    end
                end
                CMD_KILL:
                begin
                    if (!kill_ok)
                    begin
                        st_reg <= STAT_NO_PID;
                    end
                end
                CMD_TICK:
                begin
                    if (need_pick)
                    begin
                        run_prio_reg <= pick_prio;
                        run_rem_reg  <= pick_rem;
                        run_wait_reg <= pick_wait;
                    end
                end
                default:
                begin
                    st_reg <= STAT_OK;
                end
            endcase
        end
        if (state_reg == ST_RUN)
        begin
            run_rem_reg <= rem_after;
            if (run_finish)
            begin
                fpid_reg  <= runner_reg;
                fwait_reg <= run_wait_reg;
            end
            pre_reg <= run_push;
        end
        if (out_load)
        begin
            o_status_reg <= st_reg;
            o_npid_reg   <= npid_reg;
            o_run_reg    <= runner_reg;
            o_fpid_reg   <= fpid_reg;
            o_fwait_reg  <= fwait_reg;
            o_pre_reg    <= pre_reg;
            o_ticks_reg  <= ticks_reg;
            o_sw_reg     <= sw_reg;
            o_util_reg   <= util_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = o_status_reg;
    assign new_pid          = o_npid_reg;
    assign run_pid          = o_run_reg;
    assign finished_pid     = o_fpid_reg;
    assign finished_wait_ms = o_fwait_reg;
    assign preempted        = o_pre_reg;
    assign tick_count       = o_ticks_reg;
    assign switch_count     = o_sw_reg;
    assign utilization      = o_util_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (size_reg <= used_reg))
        else $error("queue holds more entries than spawned slots");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (runner_reg != '0) |-> (size_reg < used_reg) && (runner_reg <= used_reg))
        else $error("runner and queue exceed live slots");

    a_util_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (util_reg <= UTIL_MAX))
        else $error("utilization out of range");

    a_rr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && (algo_reg == ALG_RR) |-> (runner_reg == '0))
        else $error("round robin left a runner after a tick");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) && $past(state_reg == ST_SCAN)
        |-> $past(cnt_reg == SLOT_W'(MAX_PROCS - 1)))
        else $error("selection wave cut short");

endmodule
